// ===== src/acfr_pkg.sv =====
// Shared types and constants of the addressed CRC frame receiver.
// No dependencies; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package acfr_pkg;

  // CRC-16/MODBUS: reflected polynomial, all-ones start value
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Register map (byte address bit 2 picks the register)
  localparam logic REG_LOCAL_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT_MS    = 1'b1;

  localparam logic [7:0]  LOCAL_ADDRESS_RESET = 8'd0;
  localparam logic [15:0] TIMEOUT_MS_RESET    = 16'd100;

  // Where the parser stands within a frame
  typedef enum logic [1:0] {
    PH_ADDR  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  // Front end: waiting for a byte, or shifting the CRC through one byte
  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_CRC  = 1'b1
  } front_state_t;

  // Back end: no frame, RAM read in flight, result on the output
  typedef enum logic [1:0] {
    BS_IDLE  = 2'd0,
    BS_FETCH = 2'd1,
    BS_SHOW  = 2'd2
  } back_state_t;

  // One accepted frame waiting to be played out
  typedef struct packed {
    logic [6:0] len;
    logic       empty;
  } frame_desc_t;

  // Front end to queue
  typedef struct packed {
    logic        valid;
    frame_desc_t desc;
  } q_push_t;

  // Queue to back end
  typedef struct packed {
    logic        valid;
    frame_desc_t desc;
  } q_head_t;

  // One bit of the reflected CRC shift
  function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
    crc_bit_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
  endfunction

endpackage

`default_nettype wire

// ===== src/acfr_ifs.sv =====
// Valid/ready channel interfaces for received bytes and for result items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface acfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] byte_time;

  modport source (output valid, output rx_byte, output byte_time, input ready);
  modport sink   (input valid, input rx_byte, input byte_time, output ready);
endinterface

interface acfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [6:0] frame_length;
  logic       empty_frame;
  logic       last_of_frame;

  modport source (output valid, output payload_byte, output frame_length,
                  output empty_frame, output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_length,
                  input empty_frame, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== src/acfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module acfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/acfr_front.sv =====
// Front end: takes received bytes, checks the inter-byte timeout, tracks the
// frame, shifts the CRC one bit a cycle and stores payload. Uses acfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acfr_front #(
  parameter int MAX_PAYLOAD = 64,
  localparam int PosW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int AddrW = $clog2(2 * MAX_PAYLOAD)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  acfr_in_if.sink               in_rx,
  input  wire logic [7:0]       local_address,
  input  wire logic [15:0]      timeout_ms,
  input  wire logic             drain_room,
  output acfr_pkg::q_push_t     push,
  output logic                  ram_we,
  output logic      [AddrW-1:0] ram_waddr,
  output logic      [7:0]       ram_wdata
);

  import acfr_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  front_state_t state_r, state_nxt;
  logic [2:0]   bit_cnt_r, bit_cnt_nxt;
  phase_t       phase_r, phase_nxt;
  logic [7:0]   addr_r, addr_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [7:0]   pos_r, pos_nxt;
  logic [15:0]  crc_r, crc_nxt;
  logic [7:0]   first_r, first_nxt;
  logic [31:0]  prev_r, prev_nxt;
  logic         wr_bank_r, wr_bank_nxt;

  logic         accept;
  logic [32:0]  threshold;
  logic         restart;
  phase_t       ph_e;
  logic [7:0]   addr_e, len_e, pos_e, first_e;
  logic [15:0]  crc_e;
  logic [8:0]   pos_inc;
  logic [15:0]  rx_crc;
  logic [AddrW-1:0] bank_base;

  assign in_rx.ready = (state_r == FS_IDLE) && drain_room;
  assign accept      = in_rx.valid && in_rx.ready;

  // Timeout: restart when the gap is too long or the threshold wraps
  assign threshold = {1'b0, prev_r} + {17'b0, timeout_ms};
  assign restart   = threshold[32] || (threshold[31:0] < in_rx.byte_time);

  // Frame state as seen after a possible restart
  assign ph_e    = restart ? PH_ADDR  : phase_r;
  assign addr_e  = restart ? 8'd0     : addr_r;
  assign len_e   = restart ? 8'd0     : len_r;
  assign pos_e   = restart ? 8'd0     : pos_r;
  assign first_e = restart ? 8'd0     : first_r;
  assign crc_e   = restart ? CRC_INIT : crc_r;

  assign pos_inc   = {1'b0, pos_e} + 9'd1;
  assign rx_crc    = {in_rx.rx_byte, first_e};
  assign bank_base = wr_bank_r ? AddrW'(MAX_PAYLOAD) : '0;

  // Parse and CRC sequencing
  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    wr_bank_nxt = wr_bank_r;
    push        = '0;
    ram_we      = 1'b0;
    ram_waddr   = bank_base + AddrW'(pos_e[PosW-1:0]);
    ram_wdata   = in_rx.rx_byte;

    case (state_r)
      FS_IDLE: begin
        if (accept) begin
          prev_nxt  = in_rx.byte_time;
          phase_nxt = ph_e;
          addr_nxt  = addr_e;
          len_nxt   = len_e;
          pos_nxt   = pos_e;
          first_nxt = first_e;
          crc_nxt   = crc_e;
          case (ph_e)
            PH_ADDR: begin
              addr_nxt    = in_rx.rx_byte;
              crc_nxt     = CRC_INIT ^ {8'd0, in_rx.rx_byte};
              phase_nxt   = PH_LEN;
              state_nxt   = FS_CRC;
              bit_cnt_nxt = 3'd0;
            end
            PH_LEN: begin
              len_nxt     = in_rx.rx_byte;
              crc_nxt     = crc_e ^ {8'd0, in_rx.rx_byte};
              pos_nxt     = 8'd0;
              phase_nxt   = (in_rx.rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
              state_nxt   = FS_CRC;
              bit_cnt_nxt = 3'd0;
            end
            PH_DATA: begin
              ram_we      = (pos_e < MaxLen);
              crc_nxt     = crc_e ^ {8'd0, in_rx.rx_byte};
              state_nxt   = FS_CRC;
              bit_cnt_nxt = 3'd0;
              if (pos_inc >= {1'b0, len_e}) begin
                pos_nxt   = 8'd0;
                phase_nxt = PH_CHECK;
              end else begin
                pos_nxt = pos_inc[7:0];
              end
            end
            PH_CHECK: begin
              if (pos_e == 8'd0) begin
                first_nxt = in_rx.rx_byte;
                pos_nxt   = 8'd1;
              end else begin
                // Hand a good frame addressed to us to the back end
                if ((rx_crc == crc_e) && (addr_e == local_address) &&
                    (len_e <= MaxLen)) begin
                  push.valid      = 1'b1;
                  push.desc.len   = len_e[6:0];
                  push.desc.empty = (len_e == 8'd0);
                  wr_bank_nxt     = ~wr_bank_r;
                end
                // Frame over: drop all frame state
                phase_nxt = PH_ADDR;
                addr_nxt  = 8'd0;
                len_nxt   = 8'd0;
                pos_nxt   = 8'd0;
                crc_nxt   = CRC_INIT;
                first_nxt = 8'd0;
                prev_nxt  = 32'd0;
              end
            end
            default: begin
              phase_nxt = PH_ADDR;
            end
          endcase
        end
      end
      FS_CRC: begin
        // Advance the CRC one bit per cycle
        crc_nxt     = crc_bit_step(crc_r);
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FS_IDLE;
      bit_cnt_r <= 3'd0;
      phase_r   <= PH_ADDR;
      addr_r    <= 8'd0;
      len_r     <= 8'd0;
      pos_r     <= 8'd0;
      crc_r     <= CRC_INIT;
      first_r   <= 8'd0;
      prev_r    <= 32'd0;
      wr_bank_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      phase_r   <= phase_nxt;
      addr_r    <= addr_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      first_r   <= first_nxt;
      prev_r    <= prev_nxt;
      wr_bank_r <= wr_bank_nxt;
    end
  end

  // A byte that feeds the CRC starts the CRC shift with the bit counter at zero
  a_crc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ph_e != PH_CHECK)) |=> (state_r == FS_CRC) && (bit_cnt_r == 3'd0))
    else $error("CRC shift did not start after a byte");

  a_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == FS_CRC) && (bit_cnt_r == 3'd7)) |=> (state_r == FS_IDLE))
    else $error("CRC shift ran past eight bits");

  // Payload is only written inside the store and in the data phase
  a_store_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (accept && (ph_e == PH_DATA) && (pos_e < MaxLen)))
    else $error("payload write outside the store");

  // Releasing a frame, which only its second CRC byte does, clears the parser
  a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> (phase_r == PH_ADDR) && (prev_r == 32'd0))
    else $error("frame released without clearing the parser");

endmodule

`default_nettype wire

// ===== src/acfr_queue.sv =====
// Two-entry queue of accepted frame descriptors between front and back end.
// Uses acfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acfr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire acfr_pkg::q_push_t push,
  input  wire logic              pop,
  output acfr_pkg::q_head_t      head,
  output logic [1:0]             count
);

  import acfr_pkg::*;

  frame_desc_t entries_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign head.valid = (cnt_r != 2'd0);
  assign head.desc  = entries_r[rptr_r];
  assign count      = cnt_r;

  // Pointer and fill updates
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push.valid) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop) begin
      rptr_nxt = ~rptr_r;
    end
    case ({push.valid, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold descriptor entries
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wptr_r] <= push.desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (cnt_r != 2'd2))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != 2'd0))
    else $error("descriptor queue underflow");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3) && ((cnt_r == 2'd1) == (wptr_r != rptr_r)))
    else $error("descriptor queue pointers and fill disagree");

endmodule

`default_nettype wire

// ===== src/acfr_back.sv =====
// Back end: plays an accepted frame out of the payload RAM as result items,
// one RAM read per payload byte. Uses acfr_pkg and the result interface.
`timescale 1ns / 1ps
`default_nettype none

module acfr_back #(
  parameter int MAX_PAYLOAD = 64,
  localparam int PosW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int AddrW = $clog2(2 * MAX_PAYLOAD)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire acfr_pkg::q_head_t head,
  output logic                   pop,
  output logic                   busy,
  output logic                   ram_re,
  output logic      [AddrW-1:0]  ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  acfr_out_if.source             out_res
);

  import acfr_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [PosW-1:0]  idx_r, idx_nxt;
  logic [6:0]       len_r, len_nxt;
  logic             empty_r, empty_nxt;
  logic             last_r, last_nxt;
  logic             rd_bank_r, rd_bank_nxt;
  logic [7:0]       payload_r, payload_nxt;
  logic [AddrW-1:0] bank_base;
  logic             out_done;

  assign bank_base = rd_bank_r ? AddrW'(MAX_PAYLOAD) : '0;
  assign out_done  = out_res.valid && out_res.ready;
  assign busy      = (state_r != BS_IDLE);

  assign out_res.valid         = (state_r == BS_SHOW);
  assign out_res.payload_byte  = payload_r;
  assign out_res.frame_length  = len_r;
  assign out_res.empty_frame   = empty_r;
  assign out_res.last_of_frame = last_r;

  // Drain sequencing
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    empty_nxt   = empty_r;
    last_nxt    = last_r;
    rd_bank_nxt = rd_bank_r;
    payload_nxt = payload_r;
    pop         = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = bank_base + AddrW'(idx_r);

    case (state_r)
      BS_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          len_nxt   = head.desc.len;
          empty_nxt = head.desc.empty;
          idx_nxt   = '0;
          if (head.desc.empty) begin
            payload_nxt = 8'd0;
            last_nxt    = 1'b1;
            state_nxt   = BS_SHOW;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = bank_base;
            state_nxt = BS_FETCH;
          end
        end
      end
      BS_FETCH: begin
        payload_nxt = ram_rdata;
        last_nxt    = ((7'(idx_r) + 7'd1) == len_r);
        state_nxt   = BS_SHOW;
      end
      BS_SHOW: begin
        // Hold the result until the transfer, then step on
        if (out_done) begin
          if (last_r) begin
            rd_bank_nxt = ~rd_bank_r;
            state_nxt   = BS_IDLE;
          end else begin
            idx_nxt   = idx_r + PosW'(1);
            ram_re    = 1'b1;
            ram_raddr = bank_base + AddrW'(idx_r + PosW'(1));
            state_nxt = BS_FETCH;
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BS_IDLE;
      rd_bank_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_bank_r <= rd_bank_nxt;
    end
  end

  // Payload side of the drain, no reset needed
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    len_r     <= len_nxt;
    empty_r   <= empty_nxt;
    last_r    <= last_nxt;
    payload_r <= payload_nxt;
  end

  a_fetch_to_show: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_FETCH) |=> (state_r == BS_SHOW))
    else $error("RAM read not followed by a result");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_bank_r != $past(rd_bank_r)) |-> $past(out_done && last_r))
    else $error("read bank changed inside a frame");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.empty_frame) |->
      (out_res.last_of_frame && (out_res.frame_length == 7'd0)))
    else $error("malformed empty-frame marker");

endmodule

`default_nettype wire

// ===== src/addressed_crc_frame_receiver.sv =====
// Addressed CRC frame receiver, top level: register port, front end,
// descriptor queue, payload RAM and back end. Uses acfr_pkg and acfr_ifs.
//
// Usage
//   in_rx   : received bytes with their millisecond timestamps, valid/ready.
//   out_res : payload bytes of good frames addressed to local_address,
//             valid/ready; an empty frame gives one marker item.
//   APB     : register 0 local_address at 0x0, register 1 timeout_ms at 0x4.
// Input: an address, length or payload byte holds the input off while
//   the bit-serial CRC shift runs; a CRC byte does not start the shift.
//   Results leave one at a time: each payload item waits for its RAM
//   read, and the next read starts only once the shown item is taken.
// Result path: when the back end is free, the first result of a frame
//   follows its last CRC byte through the queue, the registered RAM read
//   and the result register; an empty frame skips the RAM read.
// Payload RAM holds two frames; while two accepted frames wait to be played
//   out, the input is held off. A stalled output stalls only the back end
//   until both frames are pending.
// Reset (synchronous, rst_n low) sets local_address 0, timeout_ms 100 and
//   empties the parser and the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module addressed_crc_frame_receiver #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  acfr_in_if.sink          in_rx,
  acfr_out_if.source       out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import acfr_pkg::*;

  localparam int AddrW = $clog2(2 * MAX_PAYLOAD);

  logic [7:0]       local_address_r;
  logic [15:0]      timeout_ms_r;
  logic             cfg_wr;
  q_push_t          push;
  q_head_t          head;
  logic             pop;
  logic [1:0]       q_count;
  logic             back_busy;
  logic             drain_room;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TIMEOUT_MS) ? {16'd0, timeout_ms_r}
                                               : {24'd0, local_address_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= LOCAL_ADDRESS_RESET;
      timeout_ms_r    <= TIMEOUT_MS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOCAL_ADDRESS) begin
        local_address_r <= pwdata[7:0];
      end else begin
        timeout_ms_r <= pwdata[15:0];
      end
    end
  end

  // Hold input while both RAM banks belong to pending frames
  assign drain_room = ({1'b0, q_count} + {2'b0, back_busy}) < 3'd2;

  acfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx         (in_rx),
    .local_address (local_address_r),
    .timeout_ms    (timeout_ms_r),
    .drain_room    (drain_room),
    .push          (push),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  acfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  acfr_ram #(
    .WIDTH (8),
    .DEPTH (2 * MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .busy      (back_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
